@@ sv/lfr_pkg.sv @@
`timescale 1ns / 1ps

package lfr_pkg;

    localparam int LED_COUNT_DEF = 32;
    localparam int EMIT_MAX      = 32;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [7:0] TARGET_RST = 8'd255;
    localparam logic [7:0] STEP_RST   = 8'd8;

    typedef enum logic [0:0] {
        REG_TARGET = 1'b0,
        REG_STEP   = 1'b1
    } reg_sel_t;

    typedef enum logic [1:0] {
        MODE_TICK = 2'd0,
        MODE_ON   = 2'd1,
        MODE_OFF  = 2'd2,
        MODE_FILL = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_FILL = 2'd1,
        ST_FADE = 2'd2,
        ST_EMIT = 2'd3
    } state_t;

    typedef struct packed {
        logic accept;
        logic fill_start;
        logic lit_wr;
        logic lit_on;
        logic fill_run;
        logic fade_run;
        logic emit_run;
        logic cnt_clr;
    } cmd_t;

    typedef struct packed {
        logic cnt_last;
        logic fade_done;
        logic emit_done;
    } sts_t;

    function automatic logic [7:0] fade_one(
        input logic [7:0] lv,
        input logic       lit,
        input logic [7:0] tgt,
        input logic [7:0] st
    );
        logic [7:0] res;
        res = lv;
        if (lit)
        begin
            if (lv < tgt)
            begin
                if (tgt < st)
                    res = tgt;
                else if (lv < (tgt - st))
                    res = lv + st;
                else
                    res = tgt;
            end
            else if (lv > tgt)
            begin
                if (lv < st)
                    res = tgt;
                else if ((lv - st) > tgt)
                    res = lv - st;
                else
                    res = tgt;
            end
        end
        else
        begin
            if (lv >= st)
                res = lv - st;
            else
                res = 8'd0;
        end
        return res;
    endfunction

endpackage

@@ sv/led_fade_ramp_engine_core.sv @@
`timescale 1ns / 1ps

// LED fade ramp engine. Keeps a level and an on flag for each of LED_COUNT LEDs.
// Input stream (s_*): tuser carries the mode (tick, light on, light off, fill),
// tdata carries the LED index and the fill count and value.
// Output stream (m_*): one transaction per LED level, produced only by a tick.
// Light on / light off: one lit flag update. Fill: one level RAM write per LED.
// Tick: a fade sweep over all LED_COUNT levels (read, step, write back through the
// single-port-pair level RAM), then min(LED_COUNT, 32) results, one per cycle
// when the receiver keeps m_tready high. tuser on each result flags whether
// any level changed since the previous frame; tlast marks the final LED.
// s_tready is high only between items; the engine takes the next item as soon
// as the last result sits in the output register.
// A stall on m_tready holds the output register and pauses the read-out.
// Reset: all levels zero, all LEDs off, change flag set, target 255, step 8.
// APB registers: 0x0 target brightness, 0x4 fade step.

module led_fade_ramp_engine_core #(
    parameter int LED_COUNT = lfr_pkg::LED_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lfr_pkg::S_TDATA_W-1:0] s_tdata,   // led_index, fill_count, fill_value
    input  logic [lfr_pkg::S_TUSER_W-1:0] s_tuser,   // mode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lfr_pkg::M_TDATA_W-1:0] m_tdata,   // out_index, out_level
    output logic                          m_tuser,   // frame_changed
    output logic                          m_tlast,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lfr_pkg::APB_AW-1:0]    paddr,
    input  logic [lfr_pkg::APB_DW-1:0]    pwdata,
    output logic [lfr_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    localparam int EMIT_N = (LED_COUNT < lfr_pkg::EMIT_MAX) ? LED_COUNT : lfr_pkg::EMIT_MAX;

    lfr_pkg::cmd_t     cmd;
    lfr_pkg::sts_t     sts;
    lfr_pkg::reg_sel_t reg_sel;
    logic [7:0]        target_reg, target_next;
    logic [7:0]        step_reg, step_next;
    logic              cfg_wr;
    logic [4:0]        out_index;
    logic [7:0]        out_level;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = lfr_pkg::reg_sel_t'(paddr[2]);

    always_comb
    begin
        target_next = target_reg;
        step_next   = step_reg;
        prdata      = '0;
        unique case (reg_sel)
            lfr_pkg::REG_TARGET:
            begin
                prdata[7:0] = target_reg;
                if (cfg_wr)
                    target_next = pwdata[7:0];
            end
            lfr_pkg::REG_STEP:
            begin
                prdata[7:0] = step_reg;
                if (cfg_wr)
                    step_next = pwdata[7:0];
            end
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= lfr_pkg::TARGET_RST;
            step_reg   <= lfr_pkg::STEP_RST;
        end
        else
        begin
            target_reg <= target_next;
            step_reg   <= step_next;
        end
    end

    lfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .mode     (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    lfr_dpath #(
        .LED_COUNT (LED_COUNT)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .led_index   (s_tdata[4:0]),
        .fill_count  (s_tdata[10:5]),
        .fill_value  (s_tdata[18:11]),
        .target      (target_reg),
        .step        (step_reg),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_index   (out_index),
        .out_level   (out_level),
        .out_changed (m_tuser),
        .out_last    (m_tlast)
    );

    assign m_tdata = {3'b000, out_level, out_index};

    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == lfr_pkg::MODE_TICK)) |=> !s_tready)
        else $error("tick taken without starting the fade sweep");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == lfr_pkg::MODE_FILL)) |=> !s_tready)
        else $error("fill taken without starting the write sweep");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata[4:0] == 5'(EMIT_N - 1)))
        else $error("frame end flagged on wrong LED");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> !s_tready)
        else $error("engine idle in the middle of a frame");

endmodule

@@ sv/lfr_ram.sv @@
`timescale 1ns / 1ps

module lfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

@@ sv/lfr_ctrl.sv @@
`timescale 1ns / 1ps

module lfr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [1:0]          mode,
    input  lfr_pkg::sts_t       sts,
    output lfr_pkg::cmd_t       cmd
);

    lfr_pkg::state_t state_reg;
    lfr_pkg::state_t state_next;
    lfr_pkg::mode_t  mode_sel;
    logic            accept;

    assign mode_sel = lfr_pkg::mode_t'(mode);
    assign s_tready = (state_reg == lfr_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lfr_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lfr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (mode_sel) inside
                        lfr_pkg::MODE_TICK:               state_next = lfr_pkg::ST_FADE;
                        lfr_pkg::MODE_FILL:               state_next = lfr_pkg::ST_FILL;
                        lfr_pkg::MODE_ON, lfr_pkg::MODE_OFF: state_next = lfr_pkg::ST_IDLE;
                        default:                          state_next = lfr_pkg::ST_IDLE;
                    endcase
                end
            end
            lfr_pkg::ST_FILL:
            begin
                if (sts.cnt_last)
                    state_next = lfr_pkg::ST_IDLE;
            end
            lfr_pkg::ST_FADE:
            begin
                if (sts.fade_done)
                    state_next = lfr_pkg::ST_EMIT;
            end
            lfr_pkg::ST_EMIT:
            begin
                if (sts.emit_done)
                    state_next = lfr_pkg::ST_IDLE;
            end
            default: state_next = lfr_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.accept     = accept;
        cmd.fill_start = accept && (mode_sel == lfr_pkg::MODE_FILL);
        cmd.lit_wr     = accept && ((mode_sel == lfr_pkg::MODE_ON) ||
                                    (mode_sel == lfr_pkg::MODE_OFF));
        cmd.lit_on     = (mode_sel == lfr_pkg::MODE_ON);
        unique case (state_reg)
            lfr_pkg::ST_IDLE: cmd.cnt_clr  = 1'b1;
            lfr_pkg::ST_FILL: cmd.fill_run = 1'b1;
            lfr_pkg::ST_FADE:
            begin
                cmd.fade_run = 1'b1;
                cmd.cnt_clr  = sts.fade_done;
            end
            lfr_pkg::ST_EMIT: cmd.emit_run = 1'b1;
            default:          cmd.cnt_clr  = 1'b1;
        endcase
    end

endmodule

@@ sv/lfr_dpath.sv @@
`timescale 1ns / 1ps

module lfr_dpath #(
    parameter int LED_COUNT = lfr_pkg::LED_COUNT_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  lfr_pkg::cmd_t cmd,
    output lfr_pkg::sts_t sts,
    input  logic [4:0]    led_index,
    input  logic [5:0]    fill_count,
    input  logic [7:0]    fill_value,
    input  logic [7:0]    target,
    input  logic [7:0]    step,
    input  logic          out_ready,
    output logic          out_valid,
    output logic [4:0]    out_index,
    output logic [7:0]    out_level,
    output logic          out_changed,
    output logic          out_last
);

    localparam int AW     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int CW     = $clog2(LED_COUNT + 1);
    localparam int EMIT_N = (LED_COUNT < lfr_pkg::EMIT_MAX) ? LED_COUNT : lfr_pkg::EMIT_MAX;
    localparam logic [CW-1:0] CNT_N     = CW'(LED_COUNT);
    localparam logic [CW-1:0] CNT_EMIT  = CW'(EMIT_N);
    localparam logic [AW-1:0] ADDR_LAST = AW'(LED_COUNT - 1);
    localparam logic [AW-1:0] EMIT_LAST = AW'(EMIT_N - 1);
    localparam logic [6:0]    SAT_N     = 7'(LED_COUNT);

    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [CW-1:0]        fill_cnt_reg, fill_cnt_next;
    logic [7:0]           fill_val_reg, fill_val_next;
    logic [LED_COUNT-1:0] lit_reg, lit_next;
    logic [LED_COUNT-1:0] vld_reg, vld_next;
    logic                 dirty_reg, dirty_next;
    logic                 wb_valid_reg, wb_valid_next;
    logic [AW-1:0]        wb_addr_reg, wb_addr_next;
    logic                 p_valid_reg, p_valid_next;
    logic [AW-1:0]        p_addr_reg, p_addr_next;
    logic                 rd_ok_reg, rd_ok_next;
    logic                 o_valid_reg, o_valid_next;
    logic [4:0]           o_index_reg, o_index_next;
    logic [7:0]           o_level_reg, o_level_next;
    logic                 o_changed_reg, o_changed_next;
    logic                 o_last_reg, o_last_next;

    logic [AW-1:0] cnt_idx;
    logic          fade_rd;
    logic          emit_rd;
    logic          load_out;
    logic          p_last;
    logic          rd_en;
    logic [7:0]    rd_data;
    logic [7:0]    rd_level;
    logic [7:0]    fade_lv;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [6:0]    cnt_wide;

    assign cnt_idx  = cnt_reg[AW-1:0];
    assign load_out = p_valid_reg && (!o_valid_reg || out_ready);
    assign fade_rd  = cmd.fade_run && (cnt_reg < CNT_N);
    assign emit_rd  = cmd.emit_run && (cnt_reg < CNT_EMIT) && (!p_valid_reg || load_out);
    assign rd_en    = fade_rd || emit_rd;
    assign p_last   = (p_addr_reg == EMIT_LAST);
    assign rd_level = rd_ok_reg ? rd_data : 8'd0;
    assign fade_lv  = lfr_pkg::fade_one(rd_level, lit_reg[wb_addr_reg], target, step);

    assign wr_en   = cmd.fill_run || wb_valid_reg;
    assign wr_addr = cmd.fill_run ? cnt_idx : wb_addr_reg;
    assign wr_data = cmd.fill_run ? ((cnt_reg < fill_cnt_reg) ? fill_val_reg : 8'd0)
                                  : fade_lv;

    lfr_ram #(
        .WIDTH (8),
        .DEPTH (LED_COUNT)
    ) u_level_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (cnt_idx),
        .rd_data (rd_data)
    );

    always_comb
    begin
        sts.cnt_last  = (cnt_idx == ADDR_LAST);
        sts.fade_done = wb_valid_reg && (wb_addr_reg == ADDR_LAST);
        sts.emit_done = load_out && p_last;
    end

    always_comb
    begin
        cnt_wide = {1'b0, fill_count};

        if (cmd.cnt_clr)
            cnt_next = '0;
        else if (rd_en || cmd.fill_run)
            cnt_next = cnt_reg + CW'(1);
        else
            cnt_next = cnt_reg;

        fill_cnt_next = fill_cnt_reg;
        fill_val_next = fill_val_reg;
        if (cmd.accept)
        begin
            fill_cnt_next = CW'((cnt_wide > SAT_N) ? SAT_N : cnt_wide);
            fill_val_next = fill_value;
        end

        lit_next = lit_reg;
        vld_next = vld_reg;
        for (int j = 0; j < LED_COUNT; j++)
        begin
            if (cmd.lit_wr && (7'(j) == {2'b00, led_index}))
                lit_next[j] = cmd.lit_on;
            if (wr_en && (wr_addr == AW'(j)))
                vld_next[j] = 1'b1;
        end

        dirty_next = dirty_reg;
        if (cmd.fill_start)
            dirty_next = 1'b1;
        else if (wb_valid_reg && (fade_lv != rd_level))
            dirty_next = 1'b1;
        else if (load_out && p_last)
            dirty_next = 1'b0;

        wb_valid_next = fade_rd;
        wb_addr_next  = cnt_idx;

        rd_ok_next = rd_en ? vld_reg[cnt_idx] : rd_ok_reg;

        p_addr_next = emit_rd ? cnt_idx : p_addr_reg;
        if (emit_rd)
            p_valid_next = 1'b1;
        else if (load_out)
            p_valid_next = 1'b0;
        else
            p_valid_next = p_valid_reg;

        o_index_next   = o_index_reg;
        o_level_next   = o_level_reg;
        o_changed_next = o_changed_reg;
        o_last_next    = o_last_reg;
        if (load_out)
        begin
            o_valid_next   = 1'b1;
            o_index_next   = 5'(p_addr_reg);
            o_level_next   = rd_level;
            o_changed_next = dirty_reg;
            o_last_next    = p_last;
        end
        else if (out_ready)
            o_valid_next = 1'b0;
        else
            o_valid_next = o_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            lit_reg      <= '0;
            vld_reg      <= '0;
            dirty_reg    <= 1'b1;
            wb_valid_reg <= 1'b0;
            p_valid_reg  <= 1'b0;
            rd_ok_reg    <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            lit_reg      <= lit_next;
            vld_reg      <= vld_next;
            dirty_reg    <= dirty_next;
            wb_valid_reg <= wb_valid_next;
            p_valid_reg  <= p_valid_next;
            rd_ok_reg    <= rd_ok_next;
            o_valid_reg  <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_cnt_reg  <= fill_cnt_next;
        fill_val_reg  <= fill_val_next;
        wb_addr_reg   <= wb_addr_next;
        p_addr_reg    <= p_addr_next;
        o_index_reg   <= o_index_next;
        o_level_reg   <= o_level_next;
        o_changed_reg <= o_changed_next;
        o_last_reg    <= o_last_next;
    end

    assign out_valid   = o_valid_reg;
    assign out_index   = o_index_reg;
    assign out_level   = o_level_reg;
    assign out_changed = o_changed_reg;
    assign out_last    = o_last_reg;

endmodule
